[sv/stable_priority_queue_unit_macros.svh]
// Assertion macros used by spq_checker.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Check a property while out of reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/spq_pkg.sv]
`default_nettype none
package spq_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_PULL   = 1'b1;

  typedef logic signed [15:0] prio_t;
  typedef logic signed [31:0] val_t;

  typedef struct packed {
    prio_t prio;
    val_t  value;
  } entry_t;

  typedef struct packed {
    logic  action;
    prio_t priority_req;
    val_t  value;
  } in_item_t;

  typedef struct packed {
    val_t pulled_value;
    logic pull_ok;
    logic insert_dropped;
    logic queue_empty;
  } out_item_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic   ins;
    logic   pull;
    entry_t new_e;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[sv/spq_stream_if.sv]
`default_nettype none
interface spq_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/spq_cell.sv]
`default_nettype none
module spq_cell #(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  wire logic               clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire logic [CNT_W-1:0]   count,
  input  wire spq_pkg::entry_t    left_e,
  input  wire logic               left_shift,
  input  wire spq_pkg::entry_t    right_e,
  output spq_pkg::entry_t         entry_r,
  output logic                    shift
);

  spq_pkg::entry_t entry_nxt;
  logic            occ;
  logic            gt;

  assign occ   = count > CNT_W'(IDX);
  assign gt    = occ && ($signed(ctrl.new_e.prio) > $signed(entry_r.prio));
  // Push the held entry one place down when the new one outranks it.
  assign shift = ctrl.ins && gt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.pull) begin
      entry_nxt = right_e;
    end else if (ctrl.ins) begin
      if (left_shift) begin
        entry_nxt = left_e;
      end else if (gt || !occ) begin
        entry_nxt = ctrl.new_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

[sv/stable_priority_queue_unit.sv]
// Stable priority queue built as a row of compare-and-shift cells.
// in_ch carries an action (insert or pull), a signed 16-bit priority and a
// signed 32-bit value; out_ch returns one item per input item: the pulled
// value, pull_ok, insert_dropped and queue_empty after the step.
// Cells hold entries in service order, highest priority first; an insert
// lands behind every entry of equal or higher priority, so ties leave in
// arrival order. Every cell compares the new priority against its own entry
// in the same cycle and the cells below the landing point shift down one
// place; a pull shifts the whole row up one place.
// The result is registered in the output register as the input is accepted.
// Throughput: one item per cycle while the receiver keeps up, set by the cell
// update and the one-deep output register.
// When the receiver stalls, the result holds in the output register and
// in_ch.ready drops until the result is taken.
// Reset clears the entry count and the output valid flag; cell contents are
// left as they are and read only after they were written.
// An insert into a full queue (CAPACITY entries) is dropped and flagged.
`default_nettype none
module stable_priority_queue_unit #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  spq_stream_if.sink   in_ch,
  spq_stream_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  spq_pkg::in_item_t   in_item;
  spq_pkg::out_item_t  out_item_r;
  spq_pkg::out_item_t  out_item_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;

  logic                accept;
  logic                is_ins;
  logic                is_pull;
  logic                full;
  spq_pkg::cell_ctrl_t ctrl;

  spq_pkg::entry_t     cell_e [CAPACITY];
  logic                cell_shift [CAPACITY];

  assign in_item = in_ch.data;

  // Take a new item whenever the output register is free or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_ins  = accept && (in_item.action == spq_pkg::ACT_INSERT);
  assign is_pull = accept && (in_item.action == spq_pkg::ACT_PULL);
  assign full    = count_r == CNT_W'(CAPACITY);

  assign ctrl.ins         = is_ins && !full;
  assign ctrl.pull        = is_pull && (count_r != '0);
  assign ctrl.new_e.prio  = in_item.priority_req;
  assign ctrl.new_e.value = in_item.value;

  // Row of cells: head at index 0, each cell sees both neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left_e;
    logic            left_shift;
    spq_pkg::entry_t right_e;

    if (i == 0) begin : g_head
      assign left_e     = ctrl.new_e;
      assign left_shift = 1'b0;
    end else begin : g_body
      assign left_e     = cell_e[i-1];
      assign left_shift = cell_shift[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = cell_e[i];
    end else begin : g_next
      assign right_e = cell_e[i+1];
    end

    spq_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_r),
      .left_e     (left_e),
      .left_shift (left_shift),
      .right_e    (right_e),
      .entry_r    (cell_e[i]),
      .shift      (cell_shift[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pull) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Build the result from the head cell before the row moves.
  always_comb begin
    out_item_nxt.pulled_value   = ctrl.pull ? cell_e[0].value : '0;
    out_item_nxt.pull_ok        = ctrl.pull;
    out_item_nxt.insert_dropped = is_ins && full;
    out_item_nxt.queue_empty    = count_nxt == '0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result until taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

endmodule
`default_nettype wire

[sv/spq_checker.sv]
`default_nettype none
`include "stable_priority_queue_unit_macros.svh"
module spq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_pulled_value,
  input wire logic        out_pull_ok,
  input wire logic        out_insert_dropped
);

  `SPQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_pulled_value), "result changed while stalled")
  `SPQ_ASSERT(a_flags_excl, out_valid |-> !(out_pull_ok && out_insert_dropped), "pull_ok and insert_dropped both set")
  `SPQ_ASSERT(a_zero_fail, out_valid && !out_pull_ok |-> out_pulled_value == 32'd0, "nonzero value without a pull")
  `SPQ_ASSERT(a_accept_result, in_valid && in_ready |=> out_valid, "accepted item gave no result")
  `SPQ_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind stable_priority_queue_unit spq_checker u_spq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_pulled_value   (out_ch.data.pulled_value),
  .out_pull_ok        (out_ch.data.pull_ok),
  .out_insert_dropped (out_ch.data.insert_dropped)
);
`default_nettype wire

[tb/spq_order_checker.sv]
`timescale 1ns / 1ps
// Watch both channels, keep a shadow of the queue contents, and compare
// every result item against the oldest prediction.
module spq_order_checker #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  spq_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  spq_pkg::out_item_t out_data,
  output int unsigned        errors,
  output int unsigned        waiting,
  output int unsigned        pulled,
  output int unsigned        dropped,
  output int unsigned        empty_pulls
);

  // Entries in service order, head first.
  spq_pkg::entry_t    ranked[$];
  spq_pkg::out_item_t due_results[$];

  function automatic spq_pkg::out_item_t apply_step(spq_pkg::in_item_t it);
    spq_pkg::out_item_t r;
    spq_pkg::entry_t    e;
    int                 slot;
    int                 i;
    r = '0;
    if (it.action == spq_pkg::ACT_INSERT) begin
      if (ranked.size() >= CAPACITY) begin
        r.insert_dropped = 1'b1;
      end else begin
        // Land behind every entry of equal or higher priority.
        slot = ranked.size();
        for (i = 0; i < ranked.size(); i++) begin
          if ($signed(it.priority_req) > $signed(ranked[i].prio)) begin
            slot = i;
            break;
          end
        end
        e.prio  = it.priority_req;
        e.value = it.value;
        ranked.insert(slot, e);
      end
    end else if (ranked.size() > 0) begin
      r.pulled_value = ranked[0].value;
      r.pull_ok      = 1'b1;
      ranked.delete(0);
    end
    r.queue_empty = (ranked.size() == 0);
    return r;
  endfunction

  function automatic int unsigned diff_result(spq_pkg::out_item_t want,
                                              spq_pkg::out_item_t got);
    int unsigned bad;
    bad = 0;
    if (got.pulled_value !== want.pulled_value) begin
      $display("%0t: pulled_value expected %h got %h", $time,
               want.pulled_value, got.pulled_value);
      bad++;
    end
    if (got.pull_ok !== want.pull_ok) begin
      $display("%0t: pull_ok expected %b got %b", $time, want.pull_ok, got.pull_ok);
      bad++;
    end
    if (got.insert_dropped !== want.insert_dropped) begin
      $display("%0t: insert_dropped expected %b got %b", $time,
               want.insert_dropped, got.insert_dropped);
      bad++;
    end
    if (got.queue_empty !== want.queue_empty) begin
      $display("%0t: queue_empty expected %b got %b", $time,
               want.queue_empty, got.queue_empty);
      bad++;
    end
    return bad;
  endfunction

  always @(posedge clk) begin
    spq_pkg::out_item_t want;
    int unsigned        bad;
    bad = 0;
    if (rst_n) begin
      // Retire the result first: it always belongs to an earlier item.
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result expected none got %h", $time, out_data);
          bad = 1;
        end else begin
          want = due_results.pop_front();
          bad  = diff_result(want, out_data);
          pulled      <= pulled + want.pull_ok;
          dropped     <= dropped + want.insert_dropped;
          empty_pulls <= empty_pulls + (want.pull_ok == 1'b0 && want.insert_dropped == 1'b0
                                        && want.queue_empty == 1'b1 && want.pulled_value == '0
                                        ? 1 : 0);
        end
      end
      if (in_valid && in_ready) begin
        due_results.push_back(apply_step(in_data));
      end
    end
    errors  <= errors + bad;
    waiting <= due_results.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;

  localparam int DEPTH       = spq_pkg::CAPACITY_DEF;
  // Length of the forced result hold-off, in clock cycles.
  localparam int HOLD_CYCLES = 80;
  // Random items per idling mix.
  localparam int MIX_ITEMS   = 190;

  logic        clk;
  logic        rst_n;
  logic        hold_req;
  int unsigned send_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned items_sent;
  int unsigned errors;
  int unsigned waiting;
  int unsigned pulled;
  int unsigned dropped;
  int unsigned empty_pulls;

  spq_stream_if #(.T(spq_pkg::in_item_t))  in_ch ();
  spq_stream_if #(.T(spq_pkg::out_item_t)) out_ch ();

  stable_priority_queue_unit #(
    .CAPACITY(DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  spq_order_checker #(
    .CAPACITY(DEPTH)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_data    (in_ch.data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_ch.data),
    .errors     (errors),
    .waiting    (waiting),
    .pulled     (pulled),
    .dropped    (dropped),
    .empty_pulls(empty_pulls)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Receiver: stall at random, or hold off for a long stretch on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        // Count the hold-off here so the sender keeps offering meanwhile.
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic spq_pkg::in_item_t make_item(logic act, int prio, logic [31:0] val);
    spq_pkg::in_item_t it;
    it.action       = act;
    it.priority_req = prio[15:0];
    it.value        = val;
    return it;
  endfunction

  // Build one random item; spread picks how priorities are drawn so that
  // ties, extremes and the full range all show up.
  function automatic spq_pkg::in_item_t random_item(int unsigned ins_pct,
                                                    int unsigned spread);
    spq_pkg::in_item_t it;
    int                p;
    it.action = ($urandom_range(99) < ins_pct) ? spq_pkg::ACT_INSERT : spq_pkg::ACT_PULL;
    case (spread)
      0: begin
        p = $urandom;
      end
      1: begin
        // Narrow set around zero: plenty of equal priorities.
        p = int'($urandom_range(4)) - 2;
      end
      default: begin
        p = $urandom_range(1) ? 32'sd32767 : -32'sd32768;
      end
    endcase
    it.priority_req = p[15:0];
    case ($urandom_range(7))
      0:       it.value = '0;
      1:       it.value = '1;
      default: it.value = $urandom;
    endcase
    return it;
  endfunction

  // Offer one item after a random gap and hold it until the block takes it.
  // Leave valid high on return so back-to-back items need no second write.
  task automatic send(spq_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back.
  // The first edge lets the checker count the item just taken.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  // Random bursts with a shifting insert/pull bias, so the queue swings
  // between empty and full.
  task automatic random_run(int unsigned n);
    int unsigned left;
    int unsigned len;
    int unsigned bias;
    int unsigned spread;
    left = n;
    while (left > 0) begin
      len = $urandom_range(40, 6);
      if (len > left) len = left;
      case ($urandom_range(2))
        0:       bias = 85;
        1:       bias = 50;
        default: bias = 20;
      endcase
      spread = $urandom_range(2);
      repeat (len) send(random_item(bias, spread));
      left -= len;
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.data    <= '0;
    hold_req      = 1'b0;
    send_idle_pct = 0;
    sink_idle_pct = 0;
    items_sent    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: pull from an empty queue with junk in the unused fields.
    send(make_item(spq_pkg::ACT_PULL, 32'h0000_5a5a, 32'hdead_beef));
    // Extreme priorities and values, with ties that must leave in arrival order.
    send(make_item(spq_pkg::ACT_INSERT, 0, 32'h7fff_ffff));
    send(make_item(spq_pkg::ACT_INSERT, 32767, 32'h8000_0000));
    send(make_item(spq_pkg::ACT_INSERT, -32768, 32'hffff_ffff));
    send(make_item(spq_pkg::ACT_INSERT, 0, 32'h0000_0000));
    send(make_item(spq_pkg::ACT_INSERT, -1, 32'h5555_aaaa));
    send(make_item(spq_pkg::ACT_INSERT, 32767, 32'h0000_0001));
    send(make_item(spq_pkg::ACT_INSERT, -32768, 32'h0000_0002));
    // Drain all seven, then pull once more from the empty queue.
    repeat (8) send(make_item(spq_pkg::ACT_PULL, -1, 32'hffff_ffff));
    settle();

    // Sender idles lightly, receiver stalls heavily.
    send_idle_pct = 14;
    sink_idle_pct = 57;
    random_run(MIX_ITEMS);
    settle();

    // Swap the idling: sparse sender, eager receiver.
    send_idle_pct = 57;
    sink_idle_pct = 14;
    random_run(MIX_ITEMS);
    settle();

    // No idling. Hold results off while overfilling, so the output backs up
    // and the input stalls; the extra inserts must be dropped.
    send_idle_pct = 0;
    sink_idle_pct = 0;
    hold_req = 1'b1;
    repeat (DEPTH + 2) send(random_item(100, 0));
    repeat (DEPTH + 2) send(random_item(0, 0));
    // Pause the sender until every result is back.
    settle();
    random_run(MIX_ITEMS);
    settle();

    // Allow a few more edges to catch any stray result.
    repeat (8) @(posedge clk);
    $display("tb: %0d items, %0d pulled, %0d empty pulls, %0d inserts dropped",
             items_sent, pulled, empty_pulls, dropped);
    $display("tb: idle mixes 14/57, 57/14 and none, plus a %0d-cycle result hold-off",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/spq_pkg.sv
sv/spq_stream_if.sv
sv/spq_cell.sv
sv/stable_priority_queue_unit.sv
sv/spq_checker.sv
tb/spq_order_checker.sv
tb/tb.sv
